### rtl/core/rc6_pkg.sv
// rc6_pkg: shared types and constants for the RC6 IR symbol decoder.
// Holds the configuration register bundle, status codes and register indexes.
// No dependencies.
package rc6_pkg;

  localparam int DUR_W     = 15;
  localparam int NUM_REGS  = 6;
  localparam int REG_IDX_W = 3;
  localparam int SKIP_END  = 6;
  localparam int STATUS_W  = 2;
  localparam int ADDR_OUT_W = 8;
  localparam int CMD_OUT_W  = 7;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LEADER_MARK  = 3'd0,
    REG_LEADER_SPACE = 3'd1,
    REG_LEADER_TOL   = 3'd2,
    REG_MERGED_LIMIT = 3'd3,
    REG_EQUAL_MARGIN = 3'd4,
    REG_MID_LEVEL    = 3'd5
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DECODED = 2'd0,
    STATUS_LEADER  = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  localparam logic [DUR_W-1:0] RST_LEADER_MARK  = 15'd2666;
  localparam logic [DUR_W-1:0] RST_LEADER_SPACE = 15'd889;
  localparam logic [DUR_W-1:0] RST_LEADER_TOL   = 15'd200;
  localparam logic [DUR_W-1:0] RST_MERGED_LIMIT = 15'd700;
  localparam logic [DUR_W-1:0] RST_EQUAL_MARGIN = 15'd20;
  localparam logic [DUR_W-1:0] RST_MID_LEVEL    = 15'd460;

  typedef struct packed {
    logic [DUR_W-1:0] leader_mark;
    logic [DUR_W-1:0] leader_space;
    logic [DUR_W-1:0] leader_tol;
    logic [DUR_W-1:0] merged_limit;
    logic [DUR_W-1:0] equal_margin;
    logic [DUR_W-1:0] mid_level;
  } cfg_t;

  typedef struct packed {
    logic leader_ok;
    logic bit_one;
    logic bit_valid;
  } class_t;

endpackage

### rtl/core/rc6_bit_class.sv
// rc6_bit_class: classifies one captured symbol against the leader window
// and the merged, near-equal and difference bit rules.
// Depends on rc6_pkg.
module rc6_bit_class (
  input  logic [rc6_pkg::DUR_W-1:0] mark_time,
  input  logic [rc6_pkg::DUR_W-1:0] space_time,
  input  rc6_pkg::cfg_t             cfg,
  output rc6_pkg::class_t           result
);

  logic [rc6_pkg::DUR_W-1:0] mark_dev;
  logic [rc6_pkg::DUR_W-1:0] space_dev;
  logic [rc6_pkg::DUR_W-1:0] half_diff;
  logic                      mark_gt_space;
  logic                      space_gt_mark;
  logic                      near_equal;
  logic                      is_one;
  logic                      is_zero;

  assign mark_dev  = (mark_time > cfg.leader_mark) ? mark_time - cfg.leader_mark
                                                   : cfg.leader_mark - mark_time;
  assign space_dev = (space_time > cfg.leader_space) ? space_time - cfg.leader_space
                                                     : cfg.leader_space - space_time;

  assign mark_gt_space = mark_time > space_time;
  assign space_gt_mark = space_time > mark_time;
  assign half_diff     = mark_gt_space ? mark_time - space_time : space_time - mark_time;
  assign near_equal    = half_diff < cfg.equal_margin;

  always_comb begin
    if (space_time > cfg.merged_limit) begin
      is_one = 1'b1;
    end else if (near_equal) begin
      is_one = mark_time > cfg.mid_level;
    end else begin
      is_one = mark_gt_space;
    end
    if (mark_time > cfg.merged_limit) begin
      is_zero = 1'b1;
    end else if (near_equal) begin
      is_zero = mark_time < cfg.mid_level;
    end else begin
      is_zero = space_gt_mark;
    end
  end

  assign result.leader_ok = (mark_dev <= cfg.leader_tol) && (space_dev <= cfg.leader_tol);
  assign result.bit_one   = is_one;
  assign result.bit_valid = is_one || is_zero;

endmodule

### rtl/core/rc6_ir_symbol_decoder.sv
// rc6_ir_symbol_decoder: RC6-style IR frame decoder, one symbol per transaction.
// Depends on rc6_pkg and rc6_bit_class.
//
// Usage:
//   s_* channel carries one captured symbol per transaction: tdata holds
//   mark_time and space_time, tuser flags the first symbol of a capture.
//   m_* channel carries one result per frame: tuser is the status (decoded,
//   leader mismatch, invalid bit), tdata the address and command.
//   cfg_we/cfg_index/cfg_data write the six timing registers; write only
//   while no symbol is in flight.
//   A symbol is registered on acceptance and decoded from the input register;
//   the result of the symbol that completes the frame is registered and shown
//   on m_tvalid. One symbol is accepted every cycle while no result is held
//   back: the single decode stage between the input register and the result
//   register sets that rate. Symbols that produce no result still pass it.
//   If the receiver holds m_tready low with a result waiting, the decode
//   stage stalls and s_tready drops once the input register is full.
//   Reset (rst, synchronous) empties both registers, returns the decoder to
//   waiting for a frame start and restores the register defaults.
module rc6_ir_symbol_decoder #(
  parameter int ADDRESS_BITS = 8,
  parameter int COMMAND_BITS = 7
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [31:0]                    s_tdata,   // mark_time, space_time, zero pad
  input  logic                           s_tuser,   // frame_start
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,   // address, command, zero pad
  output logic [rc6_pkg::STATUS_W-1:0]   m_tuser,   // status
  input  logic                           cfg_we,
  input  logic [rc6_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [rc6_pkg::DUR_W-1:0]      cfg_data
);

  localparam int ADDR_END = rc6_pkg::SKIP_END + ADDRESS_BITS;
  localparam int CMD_END  = ADDR_END + COMMAND_BITS;
  localparam int POS_W    = $clog2(CMD_END + 1);
  localparam int ADDR_EXT_W = (ADDRESS_BITS > rc6_pkg::ADDR_OUT_W) ? ADDRESS_BITS
                                                                 : rc6_pkg::ADDR_OUT_W;
  localparam int CMD_EXT_W  = (COMMAND_BITS > rc6_pkg::CMD_OUT_W) ? COMMAND_BITS
                                                                : rc6_pkg::CMD_OUT_W;

  rc6_pkg::cfg_t cfg;

  logic                         in_valid;
  logic                         in_start;
  logic [rc6_pkg::DUR_W-1:0]    in_mark;
  logic [rc6_pkg::DUR_W-1:0]    in_space;

  logic [POS_W-1:0]             pos;
  logic [POS_W-1:0]             pos_next;
  logic [POS_W-1:0]             pos_inc;
  logic                         frame_active;
  logic                         frame_active_next;
  logic [ADDRESS_BITS-1:0]      addr_shift;
  logic [ADDRESS_BITS-1:0]      addr_shift_next;
  logic [COMMAND_BITS-1:0]      cmd_shift;
  logic [COMMAND_BITS-1:0]      cmd_shift_next;

  logic                         advance;
  logic                         emit;
  rc6_pkg::status_t             emit_status;
  logic [ADDR_EXT_W-1:0]        addr_ext;
  logic [CMD_EXT_W-1:0]         cmd_ext;

  logic                         out_valid;
  rc6_pkg::status_t             out_status;
  logic [rc6_pkg::ADDR_OUT_W-1:0] out_addr;
  logic [rc6_pkg::CMD_OUT_W-1:0]  out_cmd;

  rc6_pkg::class_t              cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_mark  <= rc6_pkg::RST_LEADER_MARK;
      cfg.leader_space <= rc6_pkg::RST_LEADER_SPACE;
      cfg.leader_tol   <= rc6_pkg::RST_LEADER_TOL;
      cfg.merged_limit <= rc6_pkg::RST_MERGED_LIMIT;
      cfg.equal_margin <= rc6_pkg::RST_EQUAL_MARGIN;
      cfg.mid_level    <= rc6_pkg::RST_MID_LEVEL;
    end else if (cfg_we) begin
      case (cfg_index)
        rc6_pkg::REG_LEADER_MARK:  cfg.leader_mark  <= cfg_data;
        rc6_pkg::REG_LEADER_SPACE: cfg.leader_space <= cfg_data;
        rc6_pkg::REG_LEADER_TOL:   cfg.leader_tol   <= cfg_data;
        rc6_pkg::REG_MERGED_LIMIT: cfg.merged_limit <= cfg_data;
        rc6_pkg::REG_EQUAL_MARGIN: cfg.equal_margin <= cfg_data;
        rc6_pkg::REG_MID_LEVEL:    cfg.mid_level    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_start <= s_tuser;
      in_mark  <= s_tdata[rc6_pkg::DUR_W-1:0];
      in_space <= s_tdata[2*rc6_pkg::DUR_W-1:rc6_pkg::DUR_W];
    end
  end

  rc6_bit_class u_bit_class (
    .mark_time  (in_mark),
    .space_time (in_space),
    .cfg        (cfg),
    .result     (cls)
  );

  assign pos_inc = pos + POS_W'(1);

  always_comb begin
    pos_next          = pos;
    frame_active_next = frame_active;
    addr_shift_next   = addr_shift;
    cmd_shift_next    = cmd_shift;
    emit              = 1'b0;
    emit_status       = rc6_pkg::STATUS_DECODED;
    if (advance) begin
      if (in_start) begin
        addr_shift_next = '0;
        cmd_shift_next  = '0;
        if (cls.leader_ok) begin
          frame_active_next = 1'b1;
          pos_next          = POS_W'(1);
        end else begin
          emit              = 1'b1;
          emit_status       = rc6_pkg::STATUS_LEADER;
          frame_active_next = 1'b0;
          pos_next          = '0;
        end
      end else if (frame_active) begin
        if (pos < POS_W'(rc6_pkg::SKIP_END)) begin
          pos_next = pos_inc;
        end else if (!cls.bit_valid) begin
          emit              = 1'b1;
          emit_status       = rc6_pkg::STATUS_INVALID;
          frame_active_next = 1'b0;
          pos_next          = '0;
        end else begin
          if (pos < POS_W'(ADDR_END)) begin
            addr_shift_next = (addr_shift << 1) | ADDRESS_BITS'(cls.bit_one);
          end else begin
            cmd_shift_next = (cmd_shift << 1) | COMMAND_BITS'(cls.bit_one);
          end
          pos_next = pos_inc;
          if (pos_inc >= POS_W'(CMD_END)) begin
            emit              = 1'b1;
            frame_active_next = 1'b0;
            pos_next          = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      frame_active <= 1'b0;
      addr_shift   <= '0;
      cmd_shift    <= '0;
    end else begin
      pos          <= pos_next;
      frame_active <= frame_active_next;
      addr_shift   <= addr_shift_next;
      cmd_shift    <= cmd_shift_next;
    end
  end

  assign addr_ext = ADDR_EXT_W'(addr_shift_next);
  assign cmd_ext  = CMD_EXT_W'(cmd_shift_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_status <= emit_status;
      if (emit_status == rc6_pkg::STATUS_DECODED) begin
        out_addr <= addr_ext[rc6_pkg::ADDR_OUT_W-1:0];
        out_cmd  <= cmd_ext[rc6_pkg::CMD_OUT_W-1:0];
      end else begin
        out_addr <= '0;
        out_cmd  <= '0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {1'b0, out_cmd, out_addr};

  a_active_pos_range : assert property (@(posedge clk) disable iff (rst)
    frame_active |-> (pos != '0 && pos < POS_W'(CMD_END)))
    else $error("symbol position out of range in active frame");

  a_idle_pos_zero : assert property (@(posedge clk) disable iff (rst)
    !frame_active |-> pos == '0)
    else $error("symbol position not cleared while idle");

  a_fail_clears_data : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != rc6_pkg::STATUS_DECODED) |-> m_tdata == '0)
    else $error("failed frame carries address or command");

  a_emit_ends_frame : assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |=> !frame_active)
    else $error("frame still active after result");

endmodule
